/* hdl/min_heap_priority_queue_macros.svh */
// assertion macros for the min-heap priority queue
// both macros sample on clk_i and are off while rst_ni is low
`ifndef MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define MPH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("min heap assertion failed");
// next-cycle implication
`define MPH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("min heap assertion failed");
`else
`define MPH_ASSERT_IMPL(label, ante, cons)
`define MPH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/mph_pkg.sv */
package mph_pkg;

  localparam int HEAP_DEPTH_DEF = 256;
  localparam int KEY_W          = 32;
  localparam int CAP_W          = 9;
  localparam int TOTAL_W        = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     operation;
    logic signed [KEY_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] removed_value;
    logic signed [KEY_W-1:0] top_value;
    logic                    top_valid;
    logic [TOTAL_W-1:0]      entry_total;
  } out_item_t;

endpackage

/* hdl/min_heap_priority_queue.sv */
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o in_item_i  (operation, value)
// out       output     out_valid_o / out_stall_i out_item_o (status, removed, top, count)
// cfg       input      cfg_we_i                cfg_wdata_i (capacity limit)
//
// one item at a time; a sift spends a read step and a compare / write-back step per level
// an insert climbs through S_UP_CHK and S_UP_CMP; a delete fetches the last entry, then
// walks down through S_DN_CHK and S_DN_CMP; a rejected item or a delete that empties
// the heap goes straight to S_DONE; the block passes through idle before the next accept
// reset empties the heap (count only, memory contents are don't-care) and sets limit 256
// a stalled result holds in the output register; the next item runs and waits when done
`include "min_heap_priority_queue_macros.svh"

module min_heap_priority_queue import mph_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_wdata_i
);

  localparam int AW   = $clog2(HEAP_DEPTH);
  localparam int CW   = $clog2(HEAP_DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_LAST_RD,
    S_LAST_GET,
    S_DN_CHK,
    S_DN_CMP,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           pos_q;      // heap position of the hole (1-based)
  logic signed [KEY_W-1:0] key_q;      // key being sifted
  logic signed [KEY_W-1:0] removed_q;
  logic signed [KEY_W-1:0] top_q;      // shadow copy of position 1
  status_e                 status_q;
  logic [CAP_W-1:0]        cap_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  // memory port signals
  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;
  logic [AW-1:0]    ra_addr;
  logic [AW-1:0]    rb_addr;
  logic [KEY_W-1:0] ra_data;
  logic [KEY_W-1:0] rb_data;

  mph_ram #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  // child positions of the hole, one bit wider than a count
  logic [CW:0]      left_pos;
  logic [CW:0]      right_pos;
  logic [CW:0]      count_ext;
  logic             has_left;
  logic             has_right;
  logic             pick_right;
  logic signed [KEY_W-1:0] child_key;
  logic             up_move;
  logic             dn_move;
  logic             full;
  logic [AW-1:0]    hole_addr;
  logic             out_free;

  assign left_pos  = {pos_q, 1'b0};
  assign right_pos = {pos_q, 1'b1};
  assign count_ext = {1'b0, count_q};
  assign has_left  = (left_pos <= count_ext);
  assign has_right = (right_pos <= count_ext);
  assign hole_addr = AW'(pos_q - 1'b1);

  // sift-down picks the right child only when strictly smaller
  assign pick_right = has_right && ($signed(rb_data) < $signed(ra_data));
  assign child_key  = pick_right ? $signed(rb_data) : $signed(ra_data);
  assign dn_move    = (child_key < key_q);
  // sift-up stops on an equal parent
  assign up_move    = (key_q < $signed(ra_data));

  // limits above the store act as the store depth
  assign full = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(HEAP_DEPTH));

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    we      = 1'b0;
    waddr   = hole_addr;
    wdata   = key_q;
    ra_addr = AW'((pos_q >> 1) - 1'b1);
    rb_addr = AW'(left_pos - 1'b1);
    case (state_q)
      S_UP_CHK: begin
        if (pos_q == CW'(1)) begin
          we = 1'b1;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (up_move) begin
          wdata = ra_data;
        end
      end
      S_LAST_RD: begin
        // last entry before the delete sits at the new count
        ra_addr = AW'(count_q);
      end
      S_DN_CHK: begin
        ra_addr = AW'(left_pos - 1'b1);
        rb_addr = has_right ? AW'(left_pos) : AW'(left_pos - 1'b1);
        if (!has_left) begin
          we = 1'b1;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (dn_move) begin
          wdata = child_key;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      key_q       <= '0;
      removed_q   <= '0;
      top_q       <= '0;
      status_q    <= ST_DONE;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (we && (waddr == '0)) begin
        top_q <= wdata;
      end
      // a result leaving while no new one is loaded frees the register
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_item_i.operation == OP_INSERT) begin
              removed_q <= '0;
              if (full) begin
                status_q <= ST_FULL;
                state_q  <= S_DONE;
              end else begin
                status_q <= ST_DONE;
                count_q  <= count_q + 1'b1;
                pos_q    <= count_q + 1'b1;
                key_q    <= in_item_i.value;
                state_q  <= S_UP_CHK;
              end
            end else begin
              if (count_q == '0) begin
                status_q  <= ST_EMPTY;
                removed_q <= '0;
                state_q   <= S_DONE;
              end else begin
                status_q  <= ST_DONE;
                removed_q <= top_q;
                count_q   <= count_q - 1'b1;
                state_q   <= (count_q == CW'(1)) ? S_DONE : S_LAST_RD;
              end
            end
          end
        end
        S_UP_CHK: begin
          state_q <= (pos_q == CW'(1)) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos_q   <= pos_q >> 1;
            state_q <= S_UP_CHK;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_LAST_RD: begin
          state_q <= S_LAST_GET;
        end
        S_LAST_GET: begin
          key_q   <= $signed(ra_data);
          pos_q   <= CW'(1);
          state_q <= S_DN_CHK;
        end
        S_DN_CHK: begin
          state_q <= has_left ? S_DN_CMP : S_DONE;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            pos_q   <= pick_right ? CW'(right_pos) : CW'(left_pos);
            state_q <= S_DN_CHK;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_q.status        <= status_q;
            out_q.removed_value <= removed_q;
            out_q.top_value     <= (count_q != '0) ? top_q : '0;
            out_q.top_valid     <= (count_q != '0);
            out_q.entry_total   <= TOTAL_W'(count_q);
            out_valid_q         <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // count never passes the store depth
  `MPH_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(HEAP_DEPTH))
  // a compare in sift-down only follows a read of a live left child
  `MPH_ASSERT_IMPL(a_dn_child_live, state_q == S_DN_CMP, left_pos <= count_ext)
  // count changes only when an item is taken
  `MPH_ASSERT_NEXT(a_count_busy_stable, state_q != S_IDLE, count_q == $past(count_q))

endmodule

/* hdl/mph_ram.sv */
module mph_ram import mph_pkg::*; #(
  parameter int DEPTH = HEAP_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [KEY_W-1:0] wdata_i,
  input  logic [AW-1:0]    ra_addr_i,
  input  logic [AW-1:0]    rb_addr_i,
  output logic [KEY_W-1:0] ra_data_o,
  output logic [KEY_W-1:0] rb_data_o
);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] ra_q;
  logic [KEY_W-1:0] rb_q;

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    ra_q <= mem[ra_addr_i];
    rb_q <= mem[rb_addr_i];
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

/* dv/tb_min_heap_priority_queue.sv */
`timescale 1ns / 100ps

module tb_min_heap_priority_queue;
  import mph_pkg::*;

  // run length guard, well above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 600000;
  // cycles to let the block settle around config writes and at the end
  localparam int unsigned SETTLE_CYCLES = 30;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_we_i = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata_i = '0;

  // idle rates in percent, changed between phases of the run
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // tracks the heap contents and the outcomes still owed by the block
  class heap_tracker;
    logic signed [KEY_W-1:0] slots [1:HEAP_DEPTH_DEF];
    int unsigned             fill;
    int unsigned             cap;
    out_item_t               pending_outcomes [$];
    int unsigned             mismatches;

    function new();
      fill = 0;
      cap = CAP_RESET;
      mismatches = 0;
    endfunction

    // apply one request to the tracked heap and return the outcome it gives
    function out_item_t apply_request(in_item_t req);
      out_item_t               res;
      int unsigned             lim;
      int unsigned             pos;
      int unsigned             kid;
      logic signed [KEY_W-1:0] tmp;
      lim = (cap > HEAP_DEPTH_DEF) ? HEAP_DEPTH_DEF : cap;
      res = '0;
      res.status = ST_DONE;
      if (req.operation == OP_INSERT) begin
        if (fill >= lim) begin
          res.status = ST_FULL;
        end else begin
          // append and sift up, stopping at a parent of equal key
          fill++;
          slots[fill] = req.value;
          pos = fill;
          while (pos > 1 && slots[pos] < slots[pos / 2]) begin
            tmp = slots[pos];
            slots[pos] = slots[pos / 2];
            slots[pos / 2] = tmp;
            pos = pos / 2;
          end
        end
      end else if (fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // take the root, move the last entry up, sift down toward the smaller child
        res.removed_value = slots[1];
        slots[1] = slots[fill];
        fill--;
        pos = 1;
        while (2 * pos <= fill) begin
          kid = 2 * pos;
          if (kid + 1 <= fill && slots[kid + 1] < slots[kid]) kid++;
          if (!(slots[kid] < slots[pos])) break;
          tmp = slots[pos];
          slots[pos] = slots[kid];
          slots[kid] = tmp;
          pos = kid;
        end
      end
      res.top_valid = (fill > 0);
      res.top_value = (fill > 0) ? slots[1] : '0;
      res.entry_total = TOTAL_W'(fill);
      return res;
    endfunction

    function void note_request(in_item_t req);
      pending_outcomes.push_back(apply_request(req));
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 200) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_outcomes.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.removed_value !== want.removed_value)
        report($sformatf("removed_value got %0d want %0d",
                         got.removed_value, want.removed_value));
      if (got.top_value !== want.top_value)
        report($sformatf("top_value got %0d want %0d", got.top_value, want.top_value));
      if (got.top_valid !== want.top_valid)
        report($sformatf("top_valid got %0b want %0b", got.top_valid, want.top_valid));
      if (got.entry_total !== want.entry_total)
        report($sformatf("entry_total got %0d want %0d",
                         got.entry_total, want.entry_total));
    endtask
  endclass

  heap_tracker tracker = new();

  min_heap_priority_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // result side: sample at the edge, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_item_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // hang guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // offer one item, with random idle cycles ahead of it, and wait until taken
  task automatic send_request(input op_e op, input logic signed [KEY_W-1:0] key);
    in_item_t req;
    req.operation = op;
    req.value = key;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= req;
    // item is taken at the first edge where stall is low
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(req);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic go_quiet();
    in_valid_i <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // limit writes happen only with the block idle
  task automatic set_capacity(input logic [CAP_W-1:0] lim);
    go_quiet();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    tracker.cap = lim;
    cfg_we_i <= 1'b0;
  endtask

  // keys: extremes, a narrow band for equal keys, and full-range values
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return int'($urandom_range(15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // one stretch of random traffic under a fixed limit, insert share in percent
  task automatic run_segment(input logic [CAP_W-1:0] lim, input int unsigned n,
                             input int unsigned ins_pct);
    set_capacity(lim);
    repeat (n) send_request(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE,
                            pick_key());
  endtask

  initial begin
    // hold reset, then release it on an edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver stalls heavily
    send_idle_pct = 28;
    recv_stall_pct = 81;

    // directed part under the reset limit
    send_request(OP_DELETE, 32'h1234_5678);   // delete on empty, value ignored
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sh7FFF_FFFF);  // largest key
    send_request(OP_INSERT, 32'h8000_0000);   // smallest key goes to the top
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, 32'sd5);          // equal keys stop the sift-up
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_DELETE, 32'sh7FFF_FFFF);  // value ignored on delete
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);          // equal children, left preferred

    // limit below the count: inserts refused, deletes still work
    set_capacity(9'd2);
    send_request(OP_INSERT, 32'sd9);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_INSERT, 32'sd1);          // count equals limit
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_DELETE, 32'sd0);          // empty again

    // zero limit refuses every insert
    set_capacity(9'd0);
    send_request(OP_INSERT, 32'sd3);
    send_request(OP_DELETE, 32'sd0);

    // single entry heap
    set_capacity(9'd1);
    send_request(OP_INSERT, -32'sd7);
    send_request(OP_INSERT, 32'sd8);
    send_request(OP_DELETE, 32'sd0);

    // random traffic, limit above the store acts as the store depth
    run_segment(9'd511, 150, 60);
    run_segment(9'd1, 50, 50);
    run_segment(CAP_W'($urandom_range(2, 31)), 150, 70);
    run_segment(9'd0, 30, 50);

    // now the sender idles heavily and the receiver lightly
    send_idle_pct = 81;
    recv_stall_pct = 28;
    run_segment(CAP_W'($urandom_range(32, 255)), 200, 65);
    run_segment(9'd3, 80, 40);
    run_segment(9'd256, 100, 50);

    // no idling: fill the whole store, hover near full, then drain to empty
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_segment(9'd256, 320, 92);
    run_segment(9'd256, 120, 50);
    run_segment(9'd256, 330, 8);
    run_segment(CAP_W'($urandom_range(1, 511)), 100, 50);

    go_quiet();

    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
